// File: rtl/assert_macros.svh
// Assertion helpers for the checker file of this block.
// All checks are sampled on clk and are quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check with reset qualification.
`define BQSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that must hold on every result beat.
`define BQSD_ASSERT_BEAT(label, cond, msg) \
  `BQSD_ASSERT(label, out_valid |-> (cond), msg)

`endif

// File: rtl/bqsd_pkg.sv
// ----------------------------------------------------------------------------
// bqsd_pkg
// Types, constants and codes shared by the message queue with selective drop.
// ----------------------------------------------------------------------------
package bqsd_pkg;

  // Store geometry; slot arithmetic wraps by truncation, so QUEUE_SLOTS is
  // kept a power of two.
  localparam int QUEUE_SLOTS   = 512;
  localparam int SLOT_W        = $clog2(QUEUE_SLOTS);
  localparam int CNT_W         = SLOT_W + 1;
  localparam int MAX_MSG_BYTES = 3;

  localparam int LEN_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 10;
  localparam int SOFT_W   = 10;
  localparam int CMP_W    = (CNT_W > SOFT_W) ? CNT_W : SOFT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_CODE_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_CODE_B = 2'd2;

  localparam logic [SOFT_W-1:0] SOFT_LIMIT_RESET  = 10'd256;
  localparam logic [BYTE_W-1:0] DROP_CODE_A_RESET = 8'h02;
  localparam logic [BYTE_W-1:0] DROP_CODE_B_RESET = 8'h20;
  localparam logic [LEN_W-1:0]  DROP_MIN_LEN      = 2'd2;

  // Item modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUSHED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSHED_DROP = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PUSHED_OVER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POPPED      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] msg_first;
    logic [BYTE_W-1:0] msg_second;
    logic [BYTE_W-1:0] msg_third;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    out_len;
    logic [BYTE_W-1:0]   out_first;
    logic [BYTE_W-1:0]   out_second;
    logic [BYTE_W-1:0]   out_third;
    logic [FILL_W-1:0]   fill_level;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic                load_in;    // capture the accepted item
    logic                pop_rd;     // read the head slot
    logic                pop_done;   // advance head, drop one from the count
    logic                scan_init;  // restart the scan pointer
    logic                scan_step;  // read at the scan pointer and advance it
    logic                mark_hole;  // hole sits one behind the scan pointer
    logic                move;       // write the read data into the hole
    logic                cnt_dec;    // account for the dropped message
    logic                append;     // write the new message at the tail
    logic                emit;       // load the result register
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic at_limit;
    logic more;        // scan pointer still below the count
    logic data_valid;  // read data belongs to the scan
    logic found;       // read data is a droppable message
  } dp_stat_t;

  function automatic entry_t make_entry(input in_item_t item);
    entry_t           e;
    logic [LEN_W-1:0] len;
    len  = (item.msg_len > LEN_W'(MAX_MSG_BYTES)) ? LEN_W'(MAX_MSG_BYTES)
                                                  : item.msg_len;
    e.len = len;
    e.b1  = (len >= 2'd1) ? item.msg_first  : '0;
    e.b2  = (len >= 2'd2) ? item.msg_second : '0;
    e.b3  = (len >= 2'd3) ? item.msg_third  : '0;
    return e;
  endfunction

endpackage

// File: rtl/bqsd_dpath.sv
// ----------------------------------------------------------------------------
// bqsd_dpath
// Message store, head and count registers, scan pointers, configuration and
// result register of the message queue.
// ----------------------------------------------------------------------------
module bqsd_dpath import bqsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output out_item_t             out_item
);

  logic [SOFT_W-1:0]  soft_limit_r;
  logic [BYTE_W-1:0]  drop_code_a_r;
  logic [BYTE_W-1:0]  drop_code_b_r;
  logic [SLOT_W-1:0]  head_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   hole_ofs;
  logic [SLOT_W-1:0]  wr_r;
  logic               chk_v_r;
  logic               out_valid_r;
  in_item_t           in_r;
  entry_t             rd_data_r;
  out_item_t          out_item_r;

  logic [ENTRY_W-1:0] mem [0:QUEUE_SLOTS-1];

  logic               rd_en, wr_en, hit;
  logic [SLOT_W-1:0]  rd_slot, wr_slot;
  entry_t             wr_data;

  assign hole_ofs = idx_r - CNT_W'(1);

  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r >= CNT_W'(QUEUE_SLOTS));
  assign stat.at_limit   = (CMP_W'(count_r) >= CMP_W'(soft_limit_r));
  assign stat.more       = (idx_r < count_r);
  assign stat.data_valid = chk_v_r;
  assign stat.found      = chk_v_r & hit;

  assign hit = (rd_data_r.len >= DROP_MIN_LEN) &&
               ((rd_data_r.b2 == drop_code_a_r) || (rd_data_r.b2 == drop_code_b_r));

  always_comb begin
    rd_en   = cmd.pop_rd | (cmd.scan_step & stat.more);
    rd_slot = cmd.pop_rd ? head_r : head_r + idx_r[SLOT_W-1:0];
    wr_en   = cmd.move | cmd.append;
    wr_slot = cmd.move ? head_r + wr_r : head_r + count_r[SLOT_W-1:0];
    wr_data = cmd.move ? rd_data_r : make_entry(in_r);
  end

  always_comb begin
    if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_done || cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_limit_r  <= SOFT_LIMIT_RESET;
      drop_code_a_r <= DROP_CODE_A_RESET;
      drop_code_b_r <= DROP_CODE_B_RESET;
      head_r        <= '0;
      count_r       <= '0;
      idx_r         <= '0;
      chk_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SOFT_LIMIT:  soft_limit_r  <= cfg_wdata[SOFT_W-1:0];
          REG_DROP_CODE_A: drop_code_a_r <= cfg_wdata[BYTE_W-1:0];
          REG_DROP_CODE_B: drop_code_b_r <= cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      count_r <= count_nxt;
      if (cmd.pop_done) begin
        head_r <= head_r + SLOT_W'(1);
      end
      if (cmd.scan_init) begin
        idx_r   <= '0;
        chk_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (stat.more) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        chk_v_r <= stat.more;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers and the store
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_item;
    end
    if (cmd.mark_hole) begin
      wr_r <= hole_ofs[SLOT_W-1:0];
    end else if (cmd.move) begin
      wr_r <= wr_r + SLOT_W'(1);
    end
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_t'(mem[rd_slot]);
    end
    if (cmd.emit) begin
      out_item_r.status     <= cmd.status;
      out_item_r.fill_level <= FILL_W'(count_nxt);
      if (cmd.status == ST_POPPED) begin
        out_item_r.out_len    <= rd_data_r.len;
        out_item_r.out_first  <= rd_data_r.b1;
        out_item_r.out_second <= rd_data_r.b2;
        out_item_r.out_third  <= rd_data_r.b3;
      end else begin
        out_item_r.out_len    <= '0;
        out_item_r.out_first  <= '0;
        out_item_r.out_second <= '0;
        out_item_r.out_third  <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/bqsd_ctrl.sv
// ----------------------------------------------------------------------------
// bqsd_ctrl
// Sequencer for push, scan for a droppable message, compaction and pop.
// ----------------------------------------------------------------------------
module bqsd_ctrl import bqsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_mode,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_APPEND  = 3'd3;
  localparam logic [2:0] S_POP     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       over_r, over_nxt;
  logic       drop_r, drop_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    over_nxt  = over_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          if (in_mode == MODE_POP) begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP;
            end
          end else begin
            over_nxt = stat.at_limit;
            drop_nxt = 1'b0;
            if (stat.at_limit) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              state_nxt = S_APPEND;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          cmd.mark_hole = 1'b1;
          state_nxt     = S_COMPACT;
        end else if (!stat.more) begin
          state_nxt = S_APPEND;
        end
      end
      S_COMPACT: begin
        cmd.scan_step = 1'b1;
        if (stat.data_valid) begin
          cmd.move = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          drop_nxt    = 1'b1;
          state_nxt   = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (stat.full) begin
          cmd.status = ST_REJECTED;
        end else begin
          cmd.append = 1'b1;
          cmd.status = drop_r ? ST_PUSHED_DROP : (over_r ? ST_PUSHED_OVER : ST_PUSHED);
        end
      end
      S_POP: begin
        cmd.emit     = 1'b1;
        cmd.pop_done = 1'b1;
        cmd.status   = ST_POPPED;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      over_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      over_r  <= over_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/bounded_queue_selective_drop.sv
// ----------------------------------------------------------------------------
// bounded_queue_selective_drop
// FIFO of short messages that, once the soft limit is reached, removes the
// oldest droppable message, if it finds one, before it appends a new one.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload     direction
//  -------  -------------------  ----------  ---------
//  input    start / busy         in_item     in
//  result   out_valid (strobe)   out_item    out
//  config   cfg_we               cfg_idx,    in
//                                cfg_wdata
//
//  An item is taken on a clock edge with start high and busy low.
//  Pop of an empty queue: result straight from idle; pop: head read, then result.
//  Push below the soft limit goes straight to the append step. At or above it
//  the push walks the store through its single read port, one entry a cycle, to
//  find and close up the hole.
//  Each result is a one-cycle beat on out_valid; the receiver cannot stall.
//  Reset (rst_n low, synchronous) empties the queue and restores the
//  register defaults; the store itself is not cleared, no entry is read
//  before it is written.
//
// ----------------------------------------------------------------------------
module bounded_queue_selective_drop import bqsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // result beats
  output logic                  out_valid,
  output out_item_t             out_item,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each item: decide push or pop, drive the scan and the
  // compaction, and pick the status code.
  bqsd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_item.mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Hold the store, pointers, registers and the result beat.
  bqsd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/bqsd_checker.sv
// ----------------------------------------------------------------------------
// bqsd_checker
// Port-level checks of the message queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqsd_checker import bqsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // An accepted item either is answered at once or keeps the block busy.
  `BQSD_ASSERT(a_accept_progress, (start && !busy) |=> (busy || out_valid), "item lost after accept")

  // A result beat only follows an accepted item or a busy cycle.
  `BQSD_ASSERT(a_beat_has_cause, out_valid |-> ($past(busy) || $past(start)), "spurious result")

  `BQSD_ASSERT_BEAT(a_status_code, out_item.status <= ST_EMPTY, "bad status code")

  `BQSD_ASSERT_BEAT(a_fill_bound, out_item.fill_level <= FILL_W'(QUEUE_SLOTS), "fill over capacity")

  `BQSD_ASSERT_BEAT(a_empty_pop, (out_item.status != ST_EMPTY) || ((out_item.fill_level == '0) && (out_item.out_len == '0)), "empty pop with data")

endmodule

bind bounded_queue_selective_drop bqsd_checker u_bqsd_checker (.*);

// File: tb/sv/bqsd_tb_pkg.sv
// ----------------------------------------------------------------------------
// bqsd_tb_pkg
// Checker for the message queue with selective drop. It keeps its own copy of
// the queued messages and the registers, works out the result of every
// accepted item, and compares result beats against those results in order.
// ----------------------------------------------------------------------------
package bqsd_tb_pkg;
  import bqsd_pkg::*;

  class drop_fifo_checker;
    entry_t            queued_msgs[$];
    out_item_t         due_results[$];
    logic [SOFT_W-1:0] soft_limit;
    logic [BYTE_W-1:0] code_a;
    logic [BYTE_W-1:0] code_b;
    int                errors;

    function new();
      soft_limit = SOFT_LIMIT_RESET;
      code_a     = DROP_CODE_A_RESET;
      code_b     = DROP_CODE_B_RESET;
      errors     = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SOFT_LIMIT:  soft_limit = data[SOFT_W-1:0];
        REG_DROP_CODE_A: code_a     = data[BYTE_W-1:0];
        REG_DROP_CODE_B: code_b     = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted item and queue it.
    function void accept_item(input in_item_t item);
      entry_t    msg;
      out_item_t res;
      bit        over;
      bit        dropped;
      int        k;
      res     = '0;
      over    = 1'b0;
      dropped = 1'b0;
      if (item.mode == MODE_PUSH) begin
        msg.len = item.msg_len;
        if (int'(msg.len) > MAX_MSG_BYTES) msg.len = LEN_W'(MAX_MSG_BYTES);
        // zero the bytes past the message length
        msg.b1 = (msg.len >= 2'd1) ? item.msg_first  : '0;
        msg.b2 = (msg.len >= 2'd2) ? item.msg_second : '0;
        msg.b3 = (msg.len >= 2'd3) ? item.msg_third  : '0;
        if (queued_msgs.size() >= int'(soft_limit)) begin
          over = 1'b1;
          for (k = 0; k < queued_msgs.size() && !dropped; k++) begin
            if (queued_msgs[k].len >= DROP_MIN_LEN &&
                (queued_msgs[k].b2 == code_a || queued_msgs[k].b2 == code_b)) begin
              queued_msgs.delete(k);
              dropped = 1'b1;
            end
          end
        end
        if (queued_msgs.size() >= QUEUE_SLOTS) begin
          res.status = ST_REJECTED;
        end else begin
          queued_msgs = {queued_msgs, msg};
          res.status = dropped ? ST_PUSHED_DROP : (over ? ST_PUSHED_OVER : ST_PUSHED);
        end
      end else if (queued_msgs.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        msg            = queued_msgs[0];
        queued_msgs.delete(0);
        res.status     = ST_POPPED;
        res.out_len    = msg.len;
        res.out_first  = msg.b1;
        res.out_second = msg.b2;
        res.out_third  = msg.b3;
      end
      res.fill_level = FILL_W'(queued_msgs.size());
      due_results = {due_results, res};
    endfunction

    function void field_check(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Match one result beat against the oldest outstanding result.
    function void check_beat(input out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no item outstanding: %h", got);
        errors++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      field_check("status",     16'(want.status),     16'(got.status));
      field_check("out_len",    16'(want.out_len),    16'(got.out_len));
      field_check("out_first",  16'(want.out_first),  16'(got.out_first));
      field_check("out_second", 16'(want.out_second), 16'(got.out_second));
      field_check("out_third",  16'(want.out_third),  16'(got.out_third));
      field_check("fill_level", 16'(want.fill_level), 16'(got.fill_level));
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_queue_selective_drop. A short directed run
// covers empty pops, bytes past the length, a zero and a one soft limit and
// the drop rules; random phases with changing limits and drop codes follow;
// the run ends by filling the store to test rejects and drop-while-full.
// ----------------------------------------------------------------------------
module tb;
  import bqsd_pkg::*;
  import bqsd_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register here
  localparam int IN_W         = $bits(in_item_t);
  localparam int RANDOM_ITEMS = 560;
  localparam int PHASE_ITEMS  = 80;
  // A drop scan at a full store is the slowest beat; allow it many times over.
  localparam int STALL_LIMIT  = 8 * (QUEUE_SLOTS + 16);

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  drop_fifo_checker  fifo_chk;
  logic [BYTE_W-1:0] cur_code_a   = DROP_CODE_A_RESET;
  logic [BYTE_W-1:0] cur_code_b   = DROP_CODE_B_RESET;
  int                burst_left   = 0;
  int                stall_cycles = 0;

  bounded_queue_selective_drop dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result beat; the receiver has no way to stall them.
  always @(posedge clk) begin
    if (rst_n && out_valid) fifo_chk.check_beat(out_item);
  end

  // Watchdog: count edges on which neither an item nor a result beat moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it; start stays high
  // so a following item can go back to back.
  task automatic send_item(input in_item_t item);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    fifo_chk.accept_item(item);
  endtask

  task automatic push_msg(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b1,
                          input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3);
    in_item_t item;
    item = '{MODE_PUSH, len, b1, b2, b3};
    send_item(item);
  endtask

  // Pop with junk in the message fields; the block must ignore them.
  task automatic pop_msg();
    in_item_t item;
    item      = in_item_t'(IN_W'($urandom));
    item.mode = MODE_POP;
    send_item(item);
  endtask

  // Random push, biased toward messages that the current codes make droppable.
  task automatic push_random();
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] second;
    int unsigned       pick;
    len    = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 1))
                                         : LEN_W'($urandom_range(2, 3));
    pick   = $urandom_range(0, 99);
    second = (pick < 40) ? cur_code_a : ((pick < 60) ? cur_code_b : BYTE_W'($urandom));
    push_msg(len, BYTE_W'($urandom), second, BYTE_W'($urandom));
  endtask

  // Push whose second byte stays clear of the codes used in the fill phase.
  task automatic push_plain();
    push_msg(LEN_W'($urandom), BYTE_W'($urandom),
             BYTE_W'($urandom_range(8'h40, 8'hFF)), BYTE_W'($urandom));
  endtask

  // Drop start for n > 0 edges.
  task automatic idle_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Burst pacing: a random gap before each burst of random length.
  task automatic sender_gap(input int max_gap);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap        = $urandom_range(0, max_gap);
      if (gap > 0) idle_sender(gap);
    end
  endtask

  // Hold the sender until every outstanding result has come and the block
  // is idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (fifo_chk.due_results.size() > 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Write one register; the caller lowers the write enable.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    fifo_chk.write_reg(idx, data);
  endtask

  // Reprogram all registers while idle. Code writes carry junk in the upper
  // bits, and the unused index gets a write that must change nothing.
  task automatic set_config(input logic [SOFT_W-1:0] lim, input logic [BYTE_W-1:0] a,
                            input logic [BYTE_W-1:0] b);
    wait_drained();
    cfg_write(REG_SOFT_LIMIT, lim);
    cfg_write(REG_DROP_CODE_A, {(CFG_DATA_W - BYTE_W)'($urandom), a});
    cfg_write(REG_DROP_CODE_B, {(CFG_DATA_W - BYTE_W)'($urandom), b});
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we     <= 1'b0;
    cur_code_a  = a;
    cur_code_b  = b;
  endtask

  initial begin
    int                n;
    int                phase;
    int                max_gap;
    logic [SOFT_W-1:0] lim;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    fifo_chk = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pop while empty, then every length with all-ones and
    // all-zeros bytes; bytes past the length must pop back as zero.
    pop_msg();
    push_msg(2'd0, 8'hFF, 8'hFF, 8'hFF);
    push_msg(2'd1, 8'hFF, 8'hFF, 8'hFF);
    push_msg(2'd2, 8'h00, 8'hFF, 8'hFF);
    push_msg(2'd3, 8'hFF, 8'hFF, 8'hFF);
    push_msg(2'd3, 8'h00, 8'h00, 8'h00);
    repeat (6) pop_msg();

    // Soft limit zero: every push tries a drop, even into an empty queue.
    // Codes at both extremes; a one-byte message never counts as droppable.
    set_config(10'd0, 8'hFF, 8'h00);
    push_msg(2'd3, 8'h12, 8'hFF, 8'h34);  // nothing queued: over limit
    push_msg(2'd1, 8'h55, 8'hFF, 8'h66);  // drops the first message
    push_msg(2'd2, 8'hAA, 8'h00, 8'hBB);  // lone one-byte entry: over limit
    push_msg(2'd3, 8'h01, 8'h77, 8'h02);  // drops the two-byte message
    repeat (3) pop_msg();

    // Soft limit one with the default codes.
    set_config(10'd1, DROP_CODE_A_RESET, DROP_CODE_B_RESET);
    push_msg(2'd2, 8'h90, 8'h20, 8'h00);
    push_msg(2'd2, 8'h91, 8'h02, 8'h00);
    push_msg(2'd0, 8'h00, 8'h02, 8'h00);
    repeat (2) pop_msg();

    // Random phases: new limit and codes each phase, pushes slightly ahead of
    // pops so the fill sits around the limit; every third phase runs flat out.
    for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      case ($urandom_range(0, 5))
        0:       lim = 10'd0;
        1:       lim = 10'd1;
        2:       lim = 10'd1023;
        default: lim = SOFT_W'($urandom_range(2, 48));
      endcase
      a = BYTE_W'($urandom);
      b = ($urandom_range(0, 3) == 0) ? a : BYTE_W'($urandom);
      set_config(lim, a, b);
      max_gap = (phase % 3 == 2) ? 0 : 6;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        sender_gap(max_gap);
        if ($urandom_range(0, 99) < 58) push_random();
        else pop_msg();
      end
    end

    // Drain to empty, one more pop on the empty queue.
    while (fifo_chk.queued_msgs.size() > 0) pop_msg();
    pop_msg();

    // Fill the whole store with the limit above the slot count, so no drop is
    // tried; one message in 64 carries the code used later.
    set_config(10'd1023, 8'h11, 8'h11);
    n = 0;
    while (fifo_chk.queued_msgs.size() < QUEUE_SLOTS) begin
      sender_gap(3);
      if (n % 64 == 0) push_msg(2'd3, BYTE_W'($urandom), 8'h11, BYTE_W'($urandom));
      else push_plain();
      n++;
    end
    // Full, no drop tried: reject.
    repeat (3) push_plain();

    // Limit at the slot count: each push drops one marked message while full
    // until none is left, then rejects.
    set_config(10'd512, 8'h11, 8'h00);
    repeat (10) push_plain();
    repeat (2) pop_msg();
    repeat (3) push_plain();

    wait_drained();
    repeat (QUEUE_SLOTS + 8) @(posedge clk);
    if (fifo_chk.errors == 0 && fifo_chk.due_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bqsd_pkg.sv
rtl/bqsd_dpath.sv
rtl/bqsd_ctrl.sv
rtl/bounded_queue_selective_drop.sv
rtl/bqsd_checker.sv
tb/sv/bqsd_tb_pkg.sv
tb/sv/tb.sv
